@@ rtl/shmb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package shmb_pkg;
    localparam int MAX_SPANS   = 7;
    localparam int STORE_DEPTH = 4 * MAX_SPANS;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(MAX_SPANS + 1);
    localparam int DIV_STEPS   = 17;
    localparam logic [23:0] HEAT_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [15:0] span_offset;
        logic [15:0] span_length;
        logic [15:0] span_weight;
        logic        last_span;
    } t_span_req;

    typedef struct packed {
        logic [16:0] zone_start;
        logic [16:0] zone_length;
        logic [23:0] zone_heat;
        logic        no_zones;
        logic        spans_dropped;
        logic        last_zone;
    } t_zone_req;

    typedef struct packed {
        logic [15:0] off;
        logic [16:0] len;
        logic [16:0] wt;
    } t_store_ent;

    typedef enum logic [3:0] {
        S_IDLE, S_LDA, S_PAIR, S_BWAIT, S_ZINIT, S_SCAN, S_ZDONE, S_FIN
    } t_seq_state;

    typedef enum logic [2:0] {
        C_IDLE, C_W2, C_FF, C_NUM, C_DIV, C_DONE
    } t_calc_state;
endpackage
`default_nettype wire

@@ rtl/span_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface span_if import shmb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_span_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/zone_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface zone_if import shmb_pkg::*; ();
    logic      valid;
    logic      ready;
    t_zone_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/cfg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface cfg_if ();
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/shmb_boost_calc.sv @@
`timescale 1ns / 1ps
`default_nettype none
module shmb_boost_calc import shmb_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [15:0] i_win,
    input  wire logic [15:0] i_f,
    input  wire logic [16:0] i_sum,
    output logic             o_done,
    output logic [16:0]      o_boost
);
    t_calc_state r_cst, n_cst;
    logic [15:0] r_win, r_f;
    logic [16:0] r_sum, r_q;
    logic [31:0] r_w2, r_ff;
    logic [48:0] r_rem, r_dsh;
    logic [4:0]  r_k;
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] prod;
    logic        ge;

    // one shared multiplier: win^2, f^2, then sum*f^2
    always_comb begin
        unique case (r_cst)
            C_W2:    begin mul_a = {16'b0, r_win}; mul_b = {1'b0, r_win}; end
            C_FF:    begin mul_a = {16'b0, r_f};   mul_b = {1'b0, r_f};   end
            C_NUM:   begin mul_a = r_ff;           mul_b = r_sum;         end
            default: begin mul_a = '0;             mul_b = '0;            end
        endcase
    end
    assign prod = 49'(mul_a) * 49'(mul_b);
    assign ge   = r_rem >= r_dsh;

    always_comb begin
        n_cst = r_cst;
        unique case (r_cst)
            C_IDLE:  if (i_start) n_cst = C_W2;
            C_W2:    n_cst = C_FF;
            C_FF:    n_cst = C_NUM;
            C_NUM:   n_cst = C_DIV;
            C_DIV:   if (r_k == 5'(DIV_STEPS - 1)) n_cst = C_DONE;
            C_DONE:  n_cst = C_IDLE;
            default: n_cst = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cst <= C_IDLE;
        else          r_cst <= n_cst;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_cst)
            C_IDLE: begin
                r_win <= i_win;
                r_f   <= i_f;
                r_sum <= i_sum;
            end
            C_W2: r_w2 <= prod[31:0];
            C_FF: r_ff <= prod[31:0];
            C_NUM: begin
                r_rem <= prod;
                r_dsh <= {1'b0, r_w2, 16'b0};
                r_q   <= '0;
                r_k   <= '0;
            end
            C_DIV: begin
                r_q   <= {r_q[15:0], ge};
                r_rem <= ge ? r_rem - r_dsh : r_rem;
                r_dsh <= r_dsh >> 1;
                r_k   <= r_k + 5'd1;
            end
            default: ;
        endcase
    end

    assign o_done  = r_cst == C_DONE;
    assign o_boost = r_q;
endmodule
`default_nettype wire

@@ rtl/span_heat_map_builder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Collects up to seven weighted spans per set, one per cycle, keeping them sorted
// by offset then length; spans beyond seven are dropped and flagged. After the last
// span the block stops taking spans: each close pair goes through the shared
// multiply/divide unit that forms the boost, other pairs are passed over, and
// each zone scans every stored span (up to 28), while a zone result waits for
// the output register to free. A new set is taken once the final result of the
// set has been placed in the output register.
module span_heat_map_builder import shmb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    span_if.sink      i_span,
    zone_if.source    o_zone,
    cfg_if.sink       i_cfg
);
    t_seq_state r_state, n_state;
    t_store_ent store [STORE_DEPTH];
    logic [15:0]      r_win;
    logic [CNT_W-1:0] r_cnt, n_cnt, r_n, n_n;
    logic             r_ovf, n_ovf, r_drop, n_drop;
    logic [IDX_W-1:0] r_tot, n_tot, r_s, n_s;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j;
    t_store_ent       r_a, n_a;
    logic [15:0]      bf;
    logic [16:0]      r_blen, n_blen;
    logic [16:0]      r_b, n_b, r_nxt, n_nxt;
    logic             r_nxt_v, n_nxt_v;
    logic [23:0]      r_heat, n_heat;
    t_zone_req        r_pend, n_pend, r_out, n_out;
    logic             r_pend_v, n_pend_v, r_ov, n_ov;

    logic [IDX_W-1:0] rd_addr;
    t_store_ent       rd;
    logic             accept, out_free, start, done, more_i, more_j, same, ins;
    logic [16:0]      boost, gapc, en, sum;
    logic [17:0]      gap;
    logic [24:0]      hsum;
    logic [CNT_W-1:0] le_cnt;
    logic [MAX_SPANS-1:0] le;
    t_span_req        sp;

    assign sp           = i_span.data;
    assign i_span.ready = r_state == S_IDLE;
    assign accept       = i_span.valid && i_span.ready;
    assign ins          = accept && (r_cnt < CNT_W'(MAX_SPANS));
    assign i_cfg.ready  = 1'b1;
    assign o_zone.valid = r_ov;
    assign o_zone.data  = r_out;
    assign out_free     = !r_ov || o_zone.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                       r_win <= 16'd1;
        else if (i_cfg.valid && i_cfg.ready) r_win <= i_cfg.data;
    end

    shmb_boost_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_win   (r_win),
        .i_f     (bf),
        .i_sum   (sum),
        .o_done  (done),
        .o_boost (boost)
    );

    always_comb begin
        unique case (r_state)
            S_LDA:   rd_addr = IDX_W'(r_i);
            S_PAIR:  rd_addr = IDX_W'(r_j);
            S_SCAN:  rd_addr = r_s;
            default: rd_addr = '0;
        endcase
    end
    assign rd = store[rd_addr];

    // sorted insertion on load
    always_comb begin
        for (int k = 0; k < MAX_SPANS; k++) begin
            le[k] = (CNT_W'(k) < r_cnt) &&
                    !((store[k].off > sp.span_offset) ||
                      (store[k].off == sp.span_offset &&
                       store[k].len[15:0] > sp.span_length));
        end
    end
    assign le_cnt = '0;

    always_ff @(posedge i_clk) begin
        if (ins) begin
            for (int k = 0; k < MAX_SPANS; k++) begin
                if (!le[k]) begin
                    if (k == 0 || le[(k == 0) ? 0 : k - 1]) begin
                        store[k] <= '{sp.span_offset, {1'b0, sp.span_length},
                                      {1'b0, sp.span_weight}};
                    end else begin
                        store[k] <= store[(k == 0) ? 0 : k - 1];
                    end
                end
            end
        end else if (r_state == S_BWAIT && done) begin
            store[r_tot] <= '{r_a.off, r_blen, boost};
        end
    end

    // pair arithmetic
    assign gap  = {2'b0, rd.off} - ({2'b0, r_a.off} + {1'b0, r_a.len});
    assign gapc = gap[17] ? 17'd0 : gap[16:0];
    assign bf   = r_win - gapc[15:0];
    assign same = (rd.off == r_a.off) && (rd.len == r_a.len);
    assign sum  = same ? {r_a.wt[15:0], 1'b0} : 17'(r_a.wt[15:0]) + 17'(rd.wt[15:0]);
    assign more_i = ({1'b0, r_i} + 4'd2) < {1'b0, r_n};
    assign more_j = ({1'b0, r_j} + 4'd1) < {1'b0, r_n};

    // zone scan arithmetic
    assign en   = 17'({1'b0, rd.off} + rd.len);
    assign hsum = {1'b0, r_heat} + 25'(rd.wt);

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_ovf = r_ovf; n_n = r_n; n_drop = r_drop;
        n_tot = r_tot; n_s = r_s; n_i = r_i; n_j = r_j; n_a = r_a;
        n_blen = r_blen; n_b = r_b; n_nxt = r_nxt; n_nxt_v = r_nxt_v;
        n_heat = r_heat; n_pend = r_pend; n_pend_v = r_pend_v;
        n_ov = r_ov && !o_zone.ready; n_out = r_out;
        start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (ins) n_cnt = r_cnt + CNT_W'(1);
                    else     n_ovf = 1'b1;
                    if (sp.last_span) begin
                        n_n    = ins ? r_cnt + CNT_W'(1) : r_cnt;
                        n_drop = r_ovf || !ins;
                        n_tot  = IDX_W'(n_n);
                        n_cnt  = '0;
                        n_ovf  = 1'b0;
                        n_i    = '0;
                        n_state = (n_n > CNT_W'(1)) ? S_LDA : S_ZINIT;
                    end
                end
            end
            S_LDA: begin
                n_a = rd;
                n_j = r_i + CNT_W'(1);
                n_state = S_PAIR;
            end
            S_PAIR: begin
                if (gapc >= {1'b0, r_win} || sum == 17'd0) begin
                    n_i = r_i + CNT_W'(1);
                    n_state = more_i ? S_LDA : S_ZINIT;
                end else begin
                    n_blen = 17'(rd.off - r_a.off) + rd.len;
                    start  = 1'b1;
                    n_state = S_BWAIT;
                end
            end
            S_BWAIT: begin
                if (done) begin
                    n_tot = r_tot + IDX_W'(1);
                    if (more_j) begin
                        n_j = r_j + CNT_W'(1);
                        n_state = S_PAIR;
                    end else begin
                        n_i = r_i + CNT_W'(1);
                        n_state = more_i ? S_LDA : S_ZINIT;
                    end
                end
            end
            S_ZINIT: begin
                n_b = {1'b0, store[0].off};
                n_pend_v = 1'b0;
                n_s = '0; n_heat = '0; n_nxt_v = 1'b0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if ({1'b0, rd.off} <= r_b && r_b < en)
                    n_heat = hsum[24] ? HEAT_MAX : hsum[23:0];
                if ({1'b0, rd.off} > r_b && (!n_nxt_v || {1'b0, rd.off} < n_nxt)) begin
                    n_nxt = {1'b0, rd.off}; n_nxt_v = 1'b1;
                end
                if (en > r_b && (!n_nxt_v || en < n_nxt)) begin
                    n_nxt = en; n_nxt_v = 1'b1;
                end
                n_s = r_s + IDX_W'(1);
                if (r_s + IDX_W'(1) == r_tot) n_state = S_ZDONE;
            end
            S_ZDONE: begin
                if (!r_nxt_v) begin
                    n_state = S_FIN;
                end else if (r_heat == 24'd0 || !r_pend_v || out_free) begin
                    if (r_heat != 24'd0) begin
                        if (r_pend_v) begin
                            n_ov = 1'b1; n_out = r_pend;
                        end
                        n_pend = '{r_b, r_nxt - r_b, r_heat, 1'b0, r_drop, 1'b0};
                        n_pend_v = 1'b1;
                    end
                    n_b = r_nxt;
                    n_s = '0; n_heat = '0; n_nxt_v = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    if (r_pend_v) begin
                        n_out = r_pend;
                        n_out.last_zone = 1'b1;
                    end else begin
                        n_out = '{17'd0, 17'd0, 24'd0, 1'b1, r_drop, 1'b1};
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_nxt_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt + le_cnt;
            r_ovf    <= n_ovf;
            r_ov     <= n_ov;
            r_pend_v <= n_pend_v;
            r_nxt_v  <= n_nxt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n <= n_n; r_drop <= n_drop; r_tot <= n_tot; r_s <= n_s; r_i <= n_i;
        r_j <= n_j; r_a <= n_a; r_blen <= n_blen;
        r_b <= n_b; r_nxt <= n_nxt; r_heat <= n_heat; r_pend <= n_pend;
        r_out <= n_out;
    end
endmodule
`default_nettype wire
